// ===== design/pttu_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette table package
// Shared codes, defaults and transaction types of the palette table block.
// ----------------------------------------------------------------------------
package pttu_pkg;

  localparam logic [1:0] ACT_BEGIN    = 2'd0;
  localparam logic [1:0] ACT_WRITE    = 2'd1;
  localparam logic [1:0] ACT_FETCH    = 2'd2;
  localparam logic [1:0] ACT_BOUNDARY = 2'd3;

  localparam logic [1:0] ST_NEVER    = 2'd0;
  localparam logic [1:0] ST_STALE    = 2'd1;
  localparam logic [1:0] ST_PROVIDED = 2'd2;
  localparam logic [1:0] ST_UPDATED  = 2'd3;

  localparam logic [1:0] MODE_IGNORE   = 2'd0;
  localparam logic [1:0] MODE_COPY_ALL = 2'd1;
  localparam logic [1:0] MODE_FLAGGED  = 2'd2;

  localparam int DEF_NUM_PALETTES = 8;
  localparam int DEF_NUM_ENTRIES  = 256;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CMD_ADDR_BITS    = 16;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] pal_num;
    logic [7:0] version;
    logic [7:0] entry_index;
    logic [7:0] entry_y;
    logic [7:0] entry_cr;
    logic [7:0] entry_cb;
    logic [7:0] entry_alpha;
    logic       entry_flagged;
    logic       must_be_current;
  } item_t;

  typedef struct packed {
    logic       found;
    logic       was_updated;
    logic [7:0] out_y;
    logic [7:0] out_cr;
    logic [7:0] out_cb;
    logic [7:0] out_alpha;
  } result_t;

  typedef struct packed {
    logic                     is_fetch;
    logic                     found;
    logic                     was_updated;
    logic                     entry_ok;
    logic [CMD_ADDR_BITS-1:0] addr;
    logic [31:0]              colour;
  } cmd_t;

endpackage

// ===== design/pttu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pttu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/pttu_queue.sv =====
// ----------------------------------------------------------------------------
// Palette table command queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module pttu_queue #(
  parameter int DEPTH = pttu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  pttu_pkg::cmd_t  push_data,
  output logic            push_ready,
  output logic            pop_valid,
  output pttu_pkg::cmd_t  pop_data,
  input  logic            pop_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pttu_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/pttu_front.sv =====
// ----------------------------------------------------------------------------
// Palette table front
// Accepts items, keeps palette status, versions and write mode, and queues
// memory writes and fetches for the back.
// ----------------------------------------------------------------------------
module pttu_front #(
  parameter int NUM_PALETTES = pttu_pkg::DEF_NUM_PALETTES,
  parameter int NUM_ENTRIES  = pttu_pkg::DEF_NUM_ENTRIES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  pttu_pkg::item_t item,
  output logic            push_valid,
  output pttu_pkg::cmd_t  push_data,
  input  logic            queue_ready
);

  localparam int PW  = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
  localparam int CAB = pttu_pkg::CMD_ADDR_BITS;

  logic [1:0]    status [NUM_PALETTES];
  logic [7:0]    pal_version [NUM_PALETTES];
  logic [1:0]    write_mode;
  logic [7:0]    open_palette;

  logic          accept;
  logic          pid_ok;
  logic          idx_ok;
  logic          open_ok;
  logic [PW-1:0] pidx;
  logic [1:0]    cur_status;
  logic [7:0]    cur_version;
  logic          do_write;
  logic          found;
  logic [7:0]    addr_pal;

  assign item_ready = queue_ready;
  assign accept     = item_valid && queue_ready;
  assign pid_ok     = (9'(item.pal_num) < 9'(NUM_PALETTES));
  assign idx_ok     = (9'(item.entry_index) < 9'(NUM_ENTRIES));
  assign open_ok    = (9'(open_palette) < 9'(NUM_PALETTES));
  assign pidx       = item.pal_num[PW-1:0];
  assign cur_status  = pid_ok ? status[pidx] : pttu_pkg::ST_NEVER;
  assign cur_version = pal_version[pidx];

  assign do_write = (write_mode == pttu_pkg::MODE_COPY_ALL) ||
                    ((write_mode == pttu_pkg::MODE_FLAGGED) && item.entry_flagged);

  assign found = pid_ok && (cur_status != pttu_pkg::ST_NEVER) &&
                 !((cur_status == pttu_pkg::ST_STALE) && item.must_be_current);

  assign addr_pal = (item.action == pttu_pkg::ACT_FETCH) ? item.pal_num : open_palette;

  always_comb begin
    push_data.is_fetch    = (item.action == pttu_pkg::ACT_FETCH);
    push_data.found       = found;
    push_data.was_updated = found && (cur_status == pttu_pkg::ST_UPDATED);
    push_data.entry_ok    = found && idx_ok;
    push_data.addr        = CAB'(int'(addr_pal) * NUM_ENTRIES + int'(item.entry_index));
    push_data.colour      = {item.entry_y, item.entry_cr, item.entry_cb, item.entry_alpha};
  end

  assign push_valid = accept &&
                      (((item.action == pttu_pkg::ACT_WRITE) && do_write && open_ok && idx_ok) ||
                       (item.action == pttu_pkg::ACT_FETCH));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PALETTES; i++) begin
        status[i] <= pttu_pkg::ST_NEVER;
      end
      write_mode   <= pttu_pkg::MODE_IGNORE;
      open_palette <= '0;
    end else if (accept) begin
      case (item.action)
        pttu_pkg::ACT_BEGIN: begin
          open_palette <= item.pal_num;
          if (!pid_ok) begin
            write_mode <= pttu_pkg::MODE_IGNORE;
          end else if (cur_status == pttu_pkg::ST_NEVER) begin
            status[pidx] <= pttu_pkg::ST_PROVIDED;
            write_mode   <= pttu_pkg::MODE_COPY_ALL;
          end else if (cur_version != item.version) begin
            status[pidx] <= pttu_pkg::ST_UPDATED;
            write_mode   <= pttu_pkg::MODE_FLAGGED;
          end else begin
            status[pidx] <= pttu_pkg::ST_PROVIDED;
            write_mode   <= pttu_pkg::MODE_IGNORE;
          end
        end
        pttu_pkg::ACT_BOUNDARY: begin
          for (int i = 0; i < NUM_PALETTES; i++) begin
            if (status[i] == pttu_pkg::ST_PROVIDED || status[i] == pttu_pkg::ST_UPDATED) begin
              status[i] <= pttu_pkg::ST_STALE;
            end
          end
          write_mode <= pttu_pkg::MODE_IGNORE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (item.action == pttu_pkg::ACT_BEGIN) && pid_ok) begin
      pal_version[pidx] <= item.version;
    end
  end

endmodule

// ===== design/pttu_back.sv =====
// ----------------------------------------------------------------------------
// Palette table back
// Carries out queued colour writes and fetches on the colour memory and
// holds the result register.
// ----------------------------------------------------------------------------
module pttu_back #(
  parameter int NUM_PALETTES = pttu_pkg::DEF_NUM_PALETTES,
  parameter int NUM_ENTRIES  = pttu_pkg::DEF_NUM_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  pttu_pkg::cmd_t    cmd,
  output logic              cmd_ready,
  output logic              result_valid,
  input  logic              result_ready,
  output pttu_pkg::result_t result
);

  localparam int DEPTH = NUM_PALETTES * NUM_ENTRIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          pop;
  logic          wr_en;
  logic          rd_en;
  logic [31:0]   rd_data;
  logic          pend;
  logic          pend_found;
  logic          pend_upd;
  logic          pend_ok;
  logic          load;

  assign cmd_ready = cmd.is_fetch ? !pend : 1'b1;
  assign pop       = cmd_valid && cmd_ready;
  assign wr_en     = pop && !cmd.is_fetch;
  assign rd_en     = pop && cmd.is_fetch && cmd.entry_ok;
  assign load      = pend && (!result_valid || result_ready);

  pttu_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_colour_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cmd.addr[AW-1:0]),
    .wr_data (cmd.colour),
    .rd_en   (rd_en),
    .rd_addr (cmd.addr[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop && cmd.is_fetch) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.is_fetch) begin
      pend_found <= cmd.found;
      pend_upd   <= cmd.was_updated;
      pend_ok    <= cmd.entry_ok;
    end
    if (load) begin
      result.found       <= pend_found;
      result.was_updated <= pend_upd;
      if (pend_ok) begin
        {result.out_y, result.out_cr, result.out_cb, result.out_alpha} <= rd_data;
      end else begin
        {result.out_y, result.out_cr, result.out_cb, result.out_alpha} <= '0;
      end
    end
  end

endmodule

// ===== design/palette_table_version_update.sv =====
// ----------------------------------------------------------------------------
// Palette table with version-controlled update
// Top level: front, command queue and back around the colour memory.
// ----------------------------------------------------------------------------
// The block accepts one item per cycle while its two-entry command queue has
// room; begin and boundary items are settled in the front in that cycle.
// Each colour write uses the memory write port in the back. A fetch passes
// through the registered memory read and then the result register in the
// back, and the back takes no new fetch while one is pending, so a fetch
// result must be loaded before the next fetch can leave the queue.
// The colour memory needs no clearing pass after reset.
module palette_table_version_update #(
  parameter int NUM_PALETTES = pttu_pkg::DEF_NUM_PALETTES,
  parameter int NUM_ENTRIES  = pttu_pkg::DEF_NUM_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  pttu_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output pttu_pkg::result_t result
);

  logic           q_push_valid;
  pttu_pkg::cmd_t q_push_data;
  logic           q_push_ready;
  logic           q_pop_valid;
  pttu_pkg::cmd_t q_pop_data;
  logic           q_pop_ready;

  pttu_front #(
    .NUM_PALETTES (NUM_PALETTES),
    .NUM_ENTRIES  (NUM_ENTRIES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .push_valid  (q_push_valid),
    .push_data   (q_push_data),
    .queue_ready (q_push_ready)
  );

  pttu_queue #(
    .DEPTH (pttu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_data  (q_push_data),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_data   (q_pop_data),
    .pop_ready  (q_pop_ready)
  );

  pttu_back #(
    .NUM_PALETTES (NUM_PALETTES),
    .NUM_ENTRIES  (NUM_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_pop_valid),
    .cmd          (q_pop_data),
    .cmd_ready    (q_pop_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTH
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push_valid |-> q_push_ready)
    else $error("command pushed into a full queue");

  a_not_found_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |->
      (!result.was_updated && result.out_y == 8'd0 && result.out_cr == 8'd0 &&
       result.out_cb == 8'd0 && result.out_alpha == 8'd0))
    else $error("not-found result carries nonzero fields");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Palette table testbench
// Drives begin, entry write, fetch and boundary transactions into the palette
// table. It starts with a short table of directed cases, then runs random
// definition sequences mixed with noise. A model of the palette store in the
// testbench predicts each fetch result that no directed case gives, and each
// result is compared field by field. Both handshakes idle at random, and the
// sender waits for the result stream to drain between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NPAL           = pttu_pkg::DEF_NUM_PALETTES;
  localparam int NENT           = pttu_pkg::DEF_NUM_ENTRIES;
  localparam int PHASE_ITEMS    = 400;
  localparam int NUM_PHASES     = 5;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam pttu_pkg::result_t NO_RESULT = '0;

  typedef struct packed {
    pttu_pkg::item_t   it;
    logic              typed;
    pttu_pkg::result_t res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  pttu_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  pttu_pkg::result_t result;

  logic              item_typed = 1'b0;
  pttu_pkg::result_t item_typed_res = '0;

  logic [1:0]  pal_status [NPAL];
  logic [7:0]  pal_version [NPAL];
  logic [31:0] colour_mem [NPAL][NENT];
  bit          entry_loaded [NPAL][NENT];
  logic [1:0]  cur_mode;
  logic [7:0]  cur_palette;

  pttu_pkg::result_t fetch_results [$];
  dir_row_t          dir_table [$];
  int                fail_count = 0;
  int                sent_items = 0;
  int                idle_cycles = 0;
  int                ready_hold = 0;
  bit                quiet = 1'b0;
  bit                mon_produced;
  pttu_pkg::result_t mon_pred;

  palette_table_version_update u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic advance_palette_table(input pttu_pkg::item_t it, output bit produced,
                                       output pttu_pkg::result_t res);
    logic [7:0] pid;
    logic [7:0] idx;
    pid = it.pal_num;
    idx = it.entry_index;
    produced = 1'b0;
    res = '0;
    case (it.action)
      pttu_pkg::ACT_BEGIN: begin
        cur_palette = pid;
        if (pid >= NPAL) begin
          cur_mode = pttu_pkg::MODE_IGNORE;
        end else if (pal_status[pid] == pttu_pkg::ST_NEVER) begin
          pal_version[pid] = it.version;
          pal_status[pid] = pttu_pkg::ST_PROVIDED;
          cur_mode = pttu_pkg::MODE_COPY_ALL;
        end else if (pal_version[pid] != it.version) begin
          pal_version[pid] = it.version;
          pal_status[pid] = pttu_pkg::ST_UPDATED;
          cur_mode = pttu_pkg::MODE_FLAGGED;
        end else begin
          pal_status[pid] = pttu_pkg::ST_PROVIDED;
          cur_mode = pttu_pkg::MODE_IGNORE;
        end
      end
      pttu_pkg::ACT_WRITE: begin
        if ((cur_mode == pttu_pkg::MODE_COPY_ALL ||
             (cur_mode == pttu_pkg::MODE_FLAGGED && it.entry_flagged))
            && cur_palette < NPAL && idx < NENT) begin
          colour_mem[cur_palette][idx] = {it.entry_y, it.entry_cr, it.entry_cb,
                                          it.entry_alpha};
          entry_loaded[cur_palette][idx] = 1'b1;
        end
      end
      pttu_pkg::ACT_BOUNDARY: begin
        for (int p = 0; p < NPAL; p++) begin
          if (pal_status[p] == pttu_pkg::ST_PROVIDED ||
              pal_status[p] == pttu_pkg::ST_UPDATED) begin
            pal_status[p] = pttu_pkg::ST_STALE;
          end
        end
        cur_mode = pttu_pkg::MODE_IGNORE;
      end
      default: begin
        produced = 1'b1;
        if (pid < NPAL) begin
          if (pal_status[pid] != pttu_pkg::ST_NEVER &&
              !(pal_status[pid] == pttu_pkg::ST_STALE && it.must_be_current)) begin
            res.found = 1'b1;
            res.was_updated = (pal_status[pid] == pttu_pkg::ST_UPDATED);
            if (idx < NENT) begin
              {res.out_y, res.out_cr, res.out_cb, res.out_alpha} = colour_mem[pid][idx];
            end
          end
        end
      end
    endcase
  endtask

  // A fetch of a usable palette is steered to an entry that holds a colour, or out of range if none does.
  function automatic pttu_pkg::item_t legalize(input pttu_pkg::item_t it);
    pttu_pkg::item_t f;
    int              start;
    int              k;
    bit              hit;
    f = it;
    if (f.action == pttu_pkg::ACT_FETCH && f.pal_num < NPAL && f.entry_index < NENT) begin
      if (pal_status[f.pal_num] != pttu_pkg::ST_NEVER &&
          !(pal_status[f.pal_num] == pttu_pkg::ST_STALE && f.must_be_current) &&
          !entry_loaded[f.pal_num][f.entry_index]) begin
        hit = 1'b0;
        start = $urandom_range(NENT - 1);
        for (k = 0; k < NENT && !hit; k++) begin
          if (entry_loaded[f.pal_num][(start + k) % NENT]) begin
            f.entry_index = 8'((start + k) % NENT);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          f.pal_num = 8'(NPAL + $urandom_range(255 - NPAL));
        end
      end
    end
    return f;
  endfunction

  function automatic pttu_pkg::item_t mk(input logic [1:0] act, input logic [7:0] pid,
                                         input logic [7:0] ver, input logic [7:0] idx,
                                         input logic [31:0] col, input logic flag,
                                         input logic mbc);
    return {act, pid, ver, idx, col, flag, mbc};
  endfunction

  function automatic pttu_pkg::result_t mkres(input logic found, input logic upd,
                                              input logic [31:0] col);
    return {found, upd, col};
  endfunction

  function automatic pttu_pkg::item_t scramble_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[59:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send_item(input pttu_pkg::item_t it, input bit typed,
                           input pttu_pkg::result_t typed_res);
    int              gap;
    pttu_pkg::item_t legal;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    legal = legalize(it);
    item <= legal;
    item_typed <= typed;
    item_typed_res <= typed_res;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (fetch_results.size() != 0);
  endtask

  task automatic run_definition();
    pttu_pkg::item_t it;
    int              pid;
    pid = ($urandom_range(9) == 0) ? $urandom_range(255, NPAL) : $urandom_range(NPAL - 1);
    it = scramble_item();
    it.action = pttu_pkg::ACT_BEGIN;
    it.pal_num = 8'(pid);
    if (pid < NPAL && pal_status[pid] != pttu_pkg::ST_NEVER && $urandom_range(2) == 0) begin
      it.version = pal_version[pid];
    end
    send_item(it, 1'b0, NO_RESULT);
    repeat ($urandom_range(12, 1)) begin
      it = scramble_item();
      it.action = pttu_pkg::ACT_WRITE;
      send_item(it, 1'b0, NO_RESULT);
    end
    repeat ($urandom_range(4)) begin
      it = scramble_item();
      it.action = pttu_pkg::ACT_FETCH;
      if ($urandom_range(9) < 7) begin
        it.pal_num = 8'(pid);
      end else if ($urandom_range(3) != 0) begin
        it.pal_num = 8'($urandom_range(NPAL - 1));
      end
      send_item(it, 1'b0, NO_RESULT);
    end
    if ($urandom_range(5) == 0) begin
      it = scramble_item();
      it.action = pttu_pkg::ACT_BOUNDARY;
      send_item(it, 1'b0, NO_RESULT);
    end
  endtask

  task automatic check_result(input pttu_pkg::result_t exp, input pttu_pkg::result_t act);
    if (act.found !== exp.found) begin
      $error("found: expected %0d, actual %0d", exp.found, act.found);
      fail_count++;
    end
    if (act.was_updated !== exp.was_updated) begin
      $error("was_updated: expected %0d, actual %0d", exp.was_updated, act.was_updated);
      fail_count++;
    end
    if (act.out_y !== exp.out_y) begin
      $error("out_y: expected 0x%02h, actual 0x%02h", exp.out_y, act.out_y);
      fail_count++;
    end
    if (act.out_cr !== exp.out_cr) begin
      $error("out_cr: expected 0x%02h, actual 0x%02h", exp.out_cr, act.out_cr);
      fail_count++;
    end
    if (act.out_cb !== exp.out_cb) begin
      $error("out_cb: expected 0x%02h, actual 0x%02h", exp.out_cb, act.out_cb);
      fail_count++;
    end
    if (act.out_alpha !== exp.out_alpha) begin
      $error("out_alpha: expected 0x%02h, actual 0x%02h", exp.out_alpha, act.out_alpha);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (fetch_results.size() == 0) begin
          $error("result transaction with no fetch outstanding");
          fail_count++;
        end else begin
          check_result(fetch_results.pop_front(), result);
        end
      end
      if (item_valid && item_ready) begin
        advance_palette_table(item, mon_produced, mon_pred);
        sent_items++;
        if (mon_produced) fetch_results.push_back(item_typed ? item_typed_res : mon_pred);
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      result_ready <= 1'b0;
      ready_hold--;
    end else if (quiet || $urandom_range(99) < 70) begin
      result_ready <= 1'b1;
    end else begin
      result_ready <= 1'b0;
      ready_hold = ($urandom_range(99) < 85) ? $urandom_range(2) : $urandom_range(40, 10);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pttu_pkg::item_t it;
    int              r;
    int              phase;
    foreach (pal_status[p]) begin
      pal_status[p] = pttu_pkg::ST_NEVER;
      pal_version[p] = '0;
    end
    cur_mode = pttu_pkg::MODE_IGNORE;
    cur_palette = '0;

    dir_table.push_back({mk(pttu_pkg::ACT_FETCH, 0, 0, 0, 32'h0, 0, 0), 1'b1,
                         mkres(0, 0, 32'h0)});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 5, 32'h12345678, 1, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_BEGIN, 0, 8'h00, 0, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 0, 32'hFFFFFFFF, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 255, 32'h00000000, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 1, 32'hA55A3CC3, 1, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_FETCH, 0, 0, 0, 32'h0, 0, 0), 1'b1,
                         mkres(1, 0, 32'hFFFFFFFF)});
    dir_table.push_back({mk(pttu_pkg::ACT_FETCH, 0, 0, 255, 32'h0, 0, 1), 1'b1,
                         mkres(1, 0, 32'h0)});
    dir_table.push_back({mk(pttu_pkg::ACT_BEGIN, 0, 8'h01, 0, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 0, 32'h11111111, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 1, 32'h22222222, 1, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_FETCH, 0, 0, 0, 32'h0, 0, 1), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_BEGIN, 0, 8'h01, 0, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 1, 32'h33333333, 1, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_FETCH, 0, 0, 1, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_BEGIN, 255, 8'hFF, 0, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 2, 32'h44444444, 1, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_FETCH, 255, 8'hFF, 255, 32'hFFFFFFFF, 1, 1),
                         1'b1, mkres(0, 0, 32'h0)});
    dir_table.push_back({mk(pttu_pkg::ACT_BOUNDARY, 0, 0, 0, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_FETCH, 0, 0, 0, 32'h0, 0, 1), 1'b1,
                         mkres(0, 0, 32'h0)});
    dir_table.push_back({mk(pttu_pkg::ACT_FETCH, 0, 0, 0, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_BEGIN, 7, 8'hFF, 0, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 255, 32'h80402010, 1, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_BOUNDARY, 0, 0, 0, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_WRITE, 0, 0, 3, 32'h55555555, 1, 0), 1'b0,
                         NO_RESULT});
    dir_table.push_back({mk(pttu_pkg::ACT_FETCH, 7, 0, 255, 32'h0, 0, 0), 1'b0,
                         NO_RESULT});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_table[i]) begin
      send_item(dir_table[i].it, dir_table[i].typed, dir_table[i].res);
    end
    drain_results();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      quiet = (phase == 2);
      while (sent_items < dir_table.size() + (phase + 1) * PHASE_ITEMS) begin
        r = $urandom_range(9);
        if (r < 7) begin
          run_definition();
        end else if (r < 8) begin
          it = scramble_item();
          it.action = pttu_pkg::ACT_BOUNDARY;
          send_item(it, 1'b0, NO_RESULT);
        end else begin
          it = scramble_item();
          if ($urandom_range(3) != 0) it.pal_num = 8'($urandom_range(NPAL - 1));
          send_item(it, 1'b0, NO_RESULT);
        end
      end
      drain_results();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
